>>> src/lvs_pkg.sv
`default_nettype none

package lvs_pkg;

  localparam int unsigned RESULT_W   = 31;
  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned CFG_DATA_W = 1;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ROOT_MODE       = 1'b0,
    REG_POPULATION_MODE = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic root_mode;
    logic population_mode;
  } cfg_t;

endpackage

`default_nettype wire

>>> src/lvs_accum.sv
`default_nettype none

module lvs_accum #(
  parameter int unsigned SAMPLE_BITS   = 16,
  parameter int unsigned MAX_LINE_LOG2 = 16
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire logic                                      take_i,
  input  wire logic signed [SAMPLE_BITS-1:0]             sample_i,
  input  wire logic                                      clear_i,
  output logic        [MAX_LINE_LOG2:0]                  count_o,
  output logic signed [MAX_LINE_LOG2+SAMPLE_BITS:0]      sum_o,
  output logic        [2*SAMPLE_BITS+MAX_LINE_LOG2-1:0]  sq_o,
  output logic                                           over_o
);
  import lvs_pkg::*;

  localparam int unsigned S  = SAMPLE_BITS;
  localparam int unsigned L  = MAX_LINE_LOG2;
  localparam int unsigned CW = L + 1;
  localparam int unsigned SW = L + S + 1;
  localparam int unsigned QW = 2 * S + L;

  logic        [CW-1:0]  count_q, count_d;
  logic signed [SW-1:0]  sum_q, sum_d;
  logic        [QW-1:0]  sq_q, sq_d;
  logic        [S-1:0]   mag;
  logic        [2*S-1:0] mag_sq;

  // |sample| fits S bits unsigned, the most negative code included
  assign mag    = sample_i[S-1] ? S'(-sample_i) : S'(sample_i);
  assign mag_sq = (2*S)'(mag) * (2*S)'(mag);

  always_comb begin
    count_d = count_q;
    sum_d   = sum_q;
    sq_d    = sq_q;
    if (clear_i) begin
      count_d = '0;
      sum_d   = '0;
      sq_d    = '0;
    end else if (take_i) begin
      if (!count_q[L]) begin
        count_d = count_q + CW'(1);
        sum_d   = sum_q + SW'(sample_i);
        sq_d    = sq_q + QW'(mag_sq);
      end else begin
        // past the limit: park the count one above it
        count_d = {1'b1, {(CW-2){1'b0}}, 1'b1};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      sq_q    <= '0;
    end else begin
      count_q <= count_d;
      sum_q   <= sum_d;
      sq_q    <= sq_d;
    end
  end

  assign count_o = count_q;
  assign sum_o   = sum_q;
  assign sq_o    = sq_q;
  assign over_o  = count_q[L] & count_q[0];

endmodule

`default_nettype wire

>>> src/lvs_seq.sv
`default_nettype none

module lvs_seq #(
  parameter int unsigned SAMPLE_BITS   = 16,
  parameter int unsigned MAX_LINE_LOG2 = 16
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire lvs_pkg::cfg_t                             cfg_i,
  input  wire logic                                      start_i,
  input  wire logic        [MAX_LINE_LOG2:0]             count_i,
  input  wire logic signed [MAX_LINE_LOG2+SAMPLE_BITS:0] sum_i,
  input  wire logic   [2*SAMPLE_BITS+MAX_LINE_LOG2-1:0]  sq_i,
  input  wire logic                                      over_i,
  input  wire logic                                      out_free_i,
  output logic                                           in_ready_o,
  output logic                                           done_o,
  output logic        [lvs_pkg::RESULT_W-1:0]            result_o,
  output logic                                           error_o
);
  import lvs_pkg::*;

  localparam int unsigned S    = SAMPLE_BITS;
  localparam int unsigned L    = MAX_LINE_LOG2;
  localparam int unsigned CW   = L + 1;
  localparam int unsigned SW   = L + S + 1;
  localparam int unsigned QW   = 2 * S + L;
  localparam int unsigned MW   = L + S;
  localparam int unsigned PW   = 2 * MW;
  localparam int unsigned AW   = PW + 2;
  localparam int unsigned K    = (QW + 1) / 2;
  localparam int unsigned CNTW = $clog2(PW + 1);
  localparam int unsigned XW   = (PW > RESULT_W) ? PW : RESULT_W + 1;

  typedef enum logic [7:0] {
    ST_ACC  = 8'b0000_0001,
    ST_PREP = 8'b0000_0010,
    ST_MUL  = 8'b0000_0100,
    ST_DIV1 = 8'b0000_1000,
    ST_CMP  = 8'b0001_0000,
    ST_DIV2 = 8'b0010_0000,
    ST_SQRT = 8'b0100_0000,
    ST_DONE = 8'b1000_0000
  } state_e;

  state_e          state_q, state_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            err_q, err_d;
  logic [AW-1:0]   acc_q, acc_d;
  logic [PW-1:0]   quo_q, quo_d;
  logic [AW-1:0]   dvs_q, dvs_d;

  // shared add/subtract unit
  logic [AW-1:0]   op_a, op_b;
  logic            op_sub;
  logic [AW:0]     add_res;
  logic [AW-1:0]   sum_w;
  logic            ge;

  logic            last_step;
  logic [MW-1:0]   mag;
  logic [CW-1:0]   div_n;
  logic [PW-1:0]   quo_next;
  logic [AW-1:0]   root_next;
  logic [XW-1:0]   wide;
  logic            done;

  assign add_res = {1'b0, op_a} + {1'b0, (op_sub ? ~op_b : op_b)} + (AW+1)'(op_sub);
  assign sum_w   = add_res[AW-1:0];
  assign ge      = add_res[AW];

  assign last_step = (cnt_q == CNTW'(1));
  assign mag       = sum_i[SW-1] ? MW'(-sum_i) : MW'(sum_i);
  assign div_n     = cfg_i.population_mode ? count_i : count_i - CW'(1);
  assign quo_next  = {quo_q[PW-2:0], ge};
  assign root_next = {dvs_q[AW-2:0], ge};

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    err_d   = err_q;
    acc_d   = acc_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    op_a    = '0;
    op_b    = '0;
    op_sub  = 1'b1;
    done    = 1'b0;
    unique case (state_q)
      ST_ACC: begin
        if (start_i) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        if (over_i || (div_n == '0)) begin
          err_d   = 1'b1;
          quo_d   = '0;
          state_d = ST_DONE;
        end else begin
          err_d   = 1'b0;
          acc_d   = '0;
          quo_d   = {mag, {(PW-MW){1'b0}}};
          dvs_d   = AW'(mag);
          cnt_d   = CNTW'(MW);
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        // sum^2, multiplier bits taken from the top
        op_sub = 1'b0;
        op_a   = {acc_q[AW-2:0], 1'b0};
        op_b   = quo_q[PW-1] ? dvs_q : '0;
        acc_d  = sum_w;
        quo_d  = {quo_q[PW-2:0], 1'b0};
        cnt_d  = cnt_q - CNTW'(1);
        if (last_step) begin
          quo_d   = sum_w[PW-1:0];
          acc_d   = '0;
          dvs_d   = AW'(count_i);
          cnt_d   = CNTW'(PW);
          state_d = ST_DIV1;
        end
      end
      ST_DIV1, ST_DIV2: begin
        // restoring divide: dividend shifts out the top, quotient in at the bottom
        op_a  = {acc_q[AW-2:0], quo_q[PW-1]};
        op_b  = dvs_q;
        acc_d = ge ? sum_w : op_a;
        quo_d = quo_next;
        cnt_d = cnt_q - CNTW'(1);
        if (last_step) begin
          if (state_q == ST_DIV1) begin
            state_d = ST_CMP;
          end else if (cfg_i.root_mode) begin
            quo_d   = quo_next << (PW - 2*K);
            acc_d   = '0;
            dvs_d   = '0;
            cnt_d   = CNTW'(K);
            state_d = ST_SQRT;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_CMP: begin
        // clamp sum2 - sum^2/n at zero
        op_a    = AW'(sq_i);
        op_b    = AW'(quo_q);
        quo_d   = ge ? (PW'(sum_w[QW-1:0]) << (PW - QW)) : '0;
        acc_d   = '0;
        dvs_d   = AW'(div_n);
        cnt_d   = CNTW'(QW);
        state_d = ST_DIV2;
      end
      ST_SQRT: begin
        // one root bit per step from the next pair of radicand bits
        op_a  = {acc_q[AW-3:0], quo_q[PW-1:PW-2]};
        op_b  = {dvs_q[AW-3:0], 2'b01};
        acc_d = ge ? sum_w : op_a;
        dvs_d = root_next;
        quo_d = {quo_q[PW-3:0], 2'b00};
        cnt_d = cnt_q - CNTW'(1);
        if (last_step) begin
          quo_d   = root_next[PW-1:0];
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold until the output register frees up
        if (out_free_i) begin
          done    = 1'b1;
          state_d = ST_ACC;
        end
      end
      default: begin
        state_d = ST_ACC;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACC;
      cnt_q   <= '0;
      err_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      err_q   <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign wide       = XW'(quo_q);
  assign result_o   = (|wide[XW-1:RESULT_W]) ? '1 : wide[RESULT_W-1:0];
  assign error_o    = err_q;
  assign done_o     = done;
  assign in_ready_o = (state_q == ST_ACC);

endmodule

`default_nettype wire

>>> src/line_variance_stddev_top.sv
`default_nettype none

// Variance or standard deviation of one line of signed samples. Samples are
// taken one per cycle while the block accumulates count, sum and sum of
// squares; the sample with last_in_line_i set closes the line. The block then
// drops in_ready_o and runs the end-of-line math through one shared
// add/subtract unit, one bit per cycle: sum squared, divide by n, clamp,
// divide by n or n-1 and, in root mode, a floor square root. The result
// sits in an output register, so the next line's samples are taken while
// it waits. Write root_mode/population_mode only between lines.
module line_variance_stddev_top #(
  parameter int unsigned SAMPLE_BITS   = 16,
  parameter int unsigned MAX_LINE_LOG2 = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [lvs_pkg::CFG_ADDR_W-1:0]       cfg_addr_i,
  input  wire logic [lvs_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic signed [SAMPLE_BITS-1:0]        sample_i,
  input  wire logic                                 last_in_line_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic [lvs_pkg::RESULT_W-1:0]              result_o,
  output logic                                      error_o
);
  import lvs_pkg::*;

  localparam int unsigned S  = SAMPLE_BITS;
  localparam int unsigned L  = MAX_LINE_LOG2;
  localparam int unsigned SW = L + S + 1;
  localparam int unsigned QW = 2 * S + L;

  cfg_t                cfg_q;
  logic                out_valid_q;
  logic [RESULT_W-1:0] result_q;
  logic                error_q;

  logic                take;
  logic                start;
  logic                clear;
  logic                out_free;
  logic                ready;
  logic [L:0]          count;
  logic signed [SW-1:0] sum;
  logic [QW-1:0]       sq;
  logic                over;
  logic [RESULT_W-1:0] seq_result;
  logic                seq_error;

  assign take     = in_valid_i & ready;
  assign start    = take & last_in_line_i;
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_addr_i))
        REG_ROOT_MODE:       cfg_q.root_mode       <= cfg_wdata_i[0];
        REG_POPULATION_MODE: cfg_q.population_mode <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  lvs_accum #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .MAX_LINE_LOG2(MAX_LINE_LOG2)
  ) u_accum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (take),
    .sample_i(sample_i),
    .clear_i (clear),
    .count_o (count),
    .sum_o   (sum),
    .sq_o    (sq),
    .over_o  (over)
  );

  lvs_seq #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .MAX_LINE_LOG2(MAX_LINE_LOG2)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .start_i   (start),
    .count_i   (count),
    .sum_i     (sum),
    .sq_i      (sq),
    .over_i    (over),
    .out_free_i(out_free),
    .in_ready_o(ready),
    .done_o    (clear),
    .result_o  (seq_result),
    .error_o   (seq_error)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (clear) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clear) begin
      result_q <= seq_result;
      error_q  <= seq_error;
    end
  end

  assign in_ready_o  = ready;
  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;
  assign error_o     = error_q;

endmodule

`default_nettype wire
